// File: sv/circle_polygon_vertex_gen_core_defines.svh
// Assertion macros used by the checker of the circle polygon vertex generator.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef CIRCLE_POLYGON_VERTEX_GEN_CORE_DEFINES_SVH
`define CIRCLE_POLYGON_VERTEX_GEN_CORE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define CPV_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CPV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/cpv_pkg.sv
// Shared constants, types and the arctangent table of the circle polygon vertex generator.
// No dependencies.
`default_nettype none
package cpv_pkg;

	localparam int PHASE_W      = 16;
	localparam int TRIG_W       = 33;
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W   = 5;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic signed [TRIG_W-1:0] GAIN_INV_Q30 = 33'sd652032874;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

	function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [TRIG_W-1:0] v;
		v = '0;
		case (idx)
			5'd0:  v = 33'sd843314856;
			5'd1:  v = 33'sd497837829;
			5'd2:  v = 33'sd263043836;
			5'd3:  v = 33'sd133525158;
			5'd4:  v = 33'sd67021686;
			5'd5:  v = 33'sd33543515;
			5'd6:  v = 33'sd16775850;
			5'd7:  v = 33'sd8388437;
			5'd8:  v = 33'sd4194282;
			5'd9:  v = 33'sd2097149;
			5'd10: v = 33'sd1048575;
			5'd11: v = 33'sd524287;
			5'd12: v = 33'sd262143;
			5'd13: v = 33'sd131071;
			5'd14: v = 33'sd65535;
			5'd15: v = 33'sd32767;
			5'd16: v = 33'sd16383;
			5'd17: v = 33'sd8191;
			5'd18: v = 33'sd4095;
			5'd19: v = 33'sd2047;
			5'd20: v = 33'sd1023;
			5'd21: v = 33'sd511;
			5'd22: v = 33'sd255;
			5'd23: v = 33'sd127;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: sv/cpv_req_if.sv
// Circle request channel: valid/ready handshake with center, radius and segment count.
// No dependencies.
`default_nettype none
interface cpv_req_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] center_x;
	logic signed [15:0] center_y;
	logic        [14:0] circle_radius;
	logic        [6:0]  segment_count;

	modport source (output valid, center_x, center_y, circle_radius, segment_count,
		input ready);
	modport sink (input valid, center_x, center_y, circle_radius, segment_count,
		output ready);
endinterface
`default_nettype wire

// File: sv/cpv_vtx_if.sv
// Vertex result channel: valid/ready handshake with coordinates, index and last flag.
// No dependencies.
`default_nettype none
interface cpv_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] vertex_x;
	logic signed [15:0] vertex_y;
	logic        [5:0]  vertex_number;
	logic               last_vertex;

	modport source (output valid, vertex_x, vertex_y, vertex_number, last_vertex,
		input ready);
	modport sink (input valid, vertex_x, vertex_y, vertex_number, last_vertex,
		output ready);
endinterface
`default_nettype wire

// File: sv/cpv_phase_div.sv
// Bit-serial restoring divider: phase = floor(i * 2^16 / n), one quotient bit per cycle.
// Depends on cpv_pkg.
`default_nettype none
module cpv_phase_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [5:0]                    numer,
	input  wire logic [6:0]                    denom,
	output cpv_pkg::unit_status_t              status,
	output logic      [cpv_pkg::PHASE_W-1:0]   quotient
);

	logic [6:0]                  rem_q;
	logic [6:0]                  den_q;
	logic [cpv_pkg::PHASE_W-1:0] quo_q;
	logic [3:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [7:0]                  shifted;
	logic                        take;

	// numer < denom, so the partial remainder always fits in seven bits
	assign shifted = {rem_q, 1'b0};
	assign take    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, numer};
			den_q <= denom;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? 7'(shifted - {1'b0, den_q}) : shifted[6:0];
			quo_q <= {quo_q[cpv_pkg::PHASE_W-2:0], take};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule
`default_nettype wire

// File: sv/cpv_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle over a shared adder set.
// Depends on cpv_pkg.
`default_nettype none
module cpv_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [cpv_pkg::TRIG_W-1:0]    angle,
	output cpv_pkg::unit_status_t                     status,
	output logic signed      [cpv_pkg::TRIG_W-1:0]    cos_out,
	output logic signed      [cpv_pkg::TRIG_W-1:0]    sin_out
);

	logic signed [cpv_pkg::TRIG_W-1:0] x_q, y_q, z_q;
	logic        [cpv_pkg::ATAN_IDX_W-1:0] k_q;
	logic                              busy_q;
	logic                              done_q;
	logic signed [cpv_pkg::TRIG_W-1:0] dx, dy, at;

	assign dx = y_q >>> k_q;
	assign dy = x_q >>> k_q;
	assign at = cpv_pkg::atan_q30(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == cpv_pkg::ATAN_IDX_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= cpv_pkg::GAIN_INV_Q30;
			y_q <= '0;
			z_q <= angle;
		end else if (busy_q) begin
			if (!z_q[cpv_pkg::TRIG_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign cos_out     = x_q;
	assign sin_out     = y_q;

endmodule
`default_nettype wire

// File: sv/circle_polygon_vertex_gen_core.sv
// Circle polygon vertex generator: one circle request in, one vertex per segment out,
// each vertex at center + radius * (cos, sin) of 2*pi*i/N, the last one flagged.
// Flow: a request is taken only while the block is idle. Each vertex passes through the
// bit-serial phase divider (16 quotient bits, then the phase is captured), the angle
// multiply, the iterative CORDIC (STEPS = min(CORDIC_STEPS, 24) micro-rotations),
// quadrant folding, radius scaling (cosine product, sine product, then the y sum) and
// the output state, which holds the vertex until it is taken. Vertices are worked one
// at a time: the next one starts only when the previous one has been taken.
// A count of zero is consumed and emits nothing; counts above MAX_SEGMENTS saturate.
// Coordinates are signed Q4.12 and wrap on overflow.
// Depends on cpv_pkg, cpv_req_if, cpv_vtx_if, cpv_phase_div, cpv_cordic.
`default_nettype none
module circle_polygon_vertex_gen_core #(
	parameter int MAX_SEGMENTS = 64,
	parameter int CORDIC_STEPS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	cpv_req_if.sink   req,
	cpv_vtx_if.source vtx
);

	localparam int STEPS = (CORDIC_STEPS < cpv_pkg::ATAN_ENTRIES) ?
		CORDIC_STEPS : cpv_pkg::ATAN_ENTRIES;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DIV  = 8'b0000_0010,
		S_ZMUL = 8'b0000_0100,
		S_ROT  = 8'b0000_1000,
		S_MULC = 8'b0001_0000,
		S_MULS = 8'b0010_0000,
		S_SUMY = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// held request
	logic signed [15:0] held_center_x_q, held_center_y_q;
	logic        [14:0] held_radius_q;
	logic        [6:0]  held_count_q;
	logic        [5:0]  vertex_counter_q;

	logic [cpv_pkg::PHASE_W-1:0]      phase_q;
	logic signed [cpv_pkg::TRIG_W-1:0] c_q, s_q;
	logic signed [48:0]               prod_q;
	logic signed [15:0]               vx_q, vy_q;

	logic        req_fire, vtx_fire, is_last;
	logic [6:0]  n_sat;
	logic        div_start;
	logic [5:0]  div_numer;
	logic [6:0]  div_denom;
	cpv_pkg::unit_status_t div_status, cor_status;
	logic [cpv_pkg::PHASE_W-1:0] div_quo;
	logic [44:0] zprod;
	logic signed [cpv_pkg::TRIG_W-1:0] cor_angle, cor_c, cor_s, trig_sel;
	logic signed [48:0] mul_out, rounded;
	logic signed [15:0] offset;

	assign req_fire = req.valid && req.ready;
	assign vtx_fire = vtx.valid && vtx.ready;
	assign is_last  = ({1'b0, vertex_counter_q} + 7'd1) == held_count_q;

	// saturate the segment count
	assign n_sat = (req.segment_count > 7'(MAX_SEGMENTS)) ?
		7'(MAX_SEGMENTS) : req.segment_count;

	// start the divider on a new request or when the next vertex begins
	assign div_start = (req_fire && n_sat != 7'd0) || (vtx_fire && !is_last);
	assign div_numer = (state_q == S_IDLE) ? 6'd0 : vertex_counter_q + 6'd1;
	assign div_denom = (state_q == S_IDLE) ? n_sat : held_count_q;

	cpv_phase_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_numer),
		.denom    (div_denom),
		.status   (div_status),
		.quotient (div_quo)
	);

	// angle inside the quadrant in Q30 radians, registered inside the CORDIC
	assign zprod     = 45'(phase_q[13:0]) * 45'(cpv_pkg::HALF_PI_Q30);
	assign cor_angle = cpv_pkg::TRIG_W'(zprod[44:14]);

	cpv_cordic #(.STEPS(STEPS)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_ZMUL),
		.angle   (cor_angle),
		.status  (cor_status),
		.cos_out (cor_c),
		.sin_out (cor_s)
	);

	// one shared multiplier scales cosine, then sine, by the radius
	assign trig_sel = (state_q == S_MULC) ? c_q : s_q;
	assign mul_out  = $signed({1'b0, held_radius_q}) * trig_sel;
	assign rounded  = (prod_q + 49'sd536870912) >>> 30;
	assign offset   = rounded[15:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_fire && n_sat != 7'd0) state_d = S_DIV;
			S_DIV:  if (div_status.done) state_d = S_ZMUL;
			S_ZMUL: state_d = S_ROT;
			S_ROT:  if (cor_status.done) state_d = S_MULC;
			S_MULC: state_d = S_MULS;
			S_MULS: state_d = S_SUMY;
			S_SUMY: state_d = S_OUT;
			S_OUT:  if (vtx_fire) state_d = is_last ? S_IDLE : S_DIV;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			vertex_counter_q <= '0;
			held_count_q     <= '0;
			held_center_x_q  <= '0;
			held_center_y_q  <= '0;
			held_radius_q    <= '0;
		end else begin
			state_q <= state_d;
			if (req_fire) begin
				held_center_x_q  <= req.center_x;
				held_center_y_q  <= req.center_y;
				held_radius_q    <= req.circle_radius;
				held_count_q     <= n_sat;
				vertex_counter_q <= '0;
			end else if (vtx_fire && !is_last) begin
				vertex_counter_q <= vertex_counter_q + 6'd1;
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_status.done)
			phase_q <= div_quo;
		if (state_q == S_ROT && cor_status.done) begin
			// fold the quadrant back in
			case (phase_q[15:14])
				2'd0: begin c_q <= cor_c;  s_q <= cor_s;  end
				2'd1: begin c_q <= -cor_s; s_q <= cor_c;  end
				2'd2: begin c_q <= -cor_c; s_q <= -cor_s; end
				default: begin c_q <= cor_s; s_q <= -cor_c; end
			endcase
		end
		if (state_q == S_MULC || state_q == S_MULS)
			prod_q <= mul_out;
		if (state_q == S_MULS)
			vx_q <= held_center_x_q + offset;
		if (state_q == S_SUMY)
			vy_q <= held_center_y_q + offset;
	end

	assign req.ready         = (state_q == S_IDLE);
	assign vtx.valid         = (state_q == S_OUT);
	assign vtx.vertex_x      = vx_q;
	assign vtx.vertex_y      = vy_q;
	assign vtx.vertex_number = vertex_counter_q;
	assign vtx.last_vertex   = is_last;

endmodule
`default_nettype wire

// File: sv/cpv_checker.sv
// Port-level checker for the circle polygon vertex generator, bound to the top level.
// Depends on circle_polygon_vertex_gen_core_defines.svh.
`default_nettype none
`include "circle_polygon_vertex_gen_core_defines.svh"
module cpv_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic vtx_valid,
	input wire logic vtx_ready,
	input wire logic vtx_last
);

	`CPV_ASSERT_NEXT(a_vtx_hold, vtx_valid && !vtx_ready, vtx_valid, "vertex valid dropped")
	`CPV_ASSERT_SAME(a_one_side, vtx_valid, !req_ready, "request taken while vertex pending")
	`CPV_ASSERT_NEXT(a_busy_mid, vtx_valid && vtx_ready && !vtx_last, !req_ready, "idle mid-circle")
	`CPV_ASSERT_NEXT(a_no_early, req_valid && req_ready, !vtx_valid, "vertex right after request")

endmodule

bind circle_polygon_vertex_gen_core cpv_checker u_cpv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.vtx_valid (vtx.valid),
	.vtx_ready (vtx.ready),
	.vtx_last  (vtx.last_vertex)
);
`default_nettype wire
